[rtl/core/life_cellular_automaton_grid_defines.svh]
// Assertion macros shared by the checker files of the cell grid block.
// No dependencies; include by bare file name.
`ifndef LIFE_CELLULAR_AUTOMATON_GRID_DEFINES_SVH
`define LIFE_CELLULAR_AUTOMATON_GRID_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GOL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define GOL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/gol_pkg.sv]
// Shared types and constants for the cell grid block.
// No dependencies; the interfaces, the row evaluator, the top level and the testbench import this package.
`timescale 1ns / 1ps

package gol_pkg;

    localparam int ACTION_W = 2;
    localparam int POS_W    = 6;
    localparam int CFG_W    = 7;
    localparam int NBR_W    = 4;

    localparam logic [NBR_W-1:0] BIRTH_COUNT   = 4'd3;
    localparam logic [NBR_W-1:0] SURVIVE_COUNT = 4'd2;

    localparam logic [CFG_W-1:0] DIM_RESET = 7'd64;

    typedef enum logic [ACTION_W-1:0] {
        ACT_WRITE = 2'd0,
        ACT_READ  = 2'd1,
        ACT_STEP  = 2'd2
    } action_t;

    typedef enum logic {
        CFG_WIDTH  = 1'b0,
        CFG_HEIGHT = 1'b1
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CELL,
        ST_STEP_LOAD,
        ST_STEP_ROW,
        ST_DONE
    } state_t;

endpackage

[rtl/core/gol_in_if.sv]
// Input channel of the cell grid block: valid/ready plus one command word.
// Depends on gol_pkg.
`timescale 1ns / 1ps

interface gol_in_if;
    import gol_pkg::*;

    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [POS_W-1:0]    row;
    logic [POS_W-1:0]    col;
    logic                cell_in;

    modport source (output valid, action, row, col, cell_in, input ready);
    modport sink   (input valid, action, row, col, cell_in, output ready);
endinterface

[rtl/core/gol_out_if.sv]
// Output channel of the cell grid block: valid/ready plus one result word.
// Depends on gol_pkg.
`timescale 1ns / 1ps

interface gol_out_if;
    import gol_pkg::*;

    logic valid;
    logic ready;
    logic cell_out;
    logic tick_done;

    modport source (output valid, cell_out, tick_done, input ready);
    modport sink   (input valid, cell_out, tick_done, output ready);
endinterface

[rtl/core/gol_row_mem.sv]
// Row storage of the cell grid: one write port, one read port, registered read.
// Depends on nothing.
`timescale 1ns / 1ps

module gol_row_mem #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule

[rtl/core/gol_row_eval.sv]
// Row evaluator: applies the B3/S23 rule to one whole row from three old rows.
// Depends on gol_pkg.
`timescale 1ns / 1ps

module gol_row_eval #(
    parameter int WIDTH = 64
) (
    input  logic [WIDTH-1:0] above,
    input  logic [WIDTH-1:0] middle,
    input  logic [WIDTH-1:0] below,
    input  logic [WIDTH-1:0] col_mask,
    output logic [WIDTH-1:0] next_row
);
    import gol_pkg::*;

    logic [WIDTH+1:0] a_pad;
    logic [WIDTH+1:0] m_pad;
    logic [WIDTH+1:0] b_pad;

    // Columns outside the active area, and the edges, read as dead.
    assign a_pad = {1'b0, above & col_mask, 1'b0};
    assign m_pad = {1'b0, middle & col_mask, 1'b0};
    assign b_pad = {1'b0, below & col_mask, 1'b0};

    for (genvar c = 0; c < WIDTH; c++)
    begin : g_col
        logic [NBR_W-1:0] count;
        logic             alive;
        logic             live_next;

        assign count = NBR_W'(a_pad[c]) + NBR_W'(a_pad[c+1]) + NBR_W'(a_pad[c+2])
                     + NBR_W'(m_pad[c]) + NBR_W'(m_pad[c+2])
                     + NBR_W'(b_pad[c]) + NBR_W'(b_pad[c+1]) + NBR_W'(b_pad[c+2]);
        assign alive     = m_pad[c+1];
        assign live_next = (count == BIRTH_COUNT) || (alive && (count == SURVIVE_COUNT));
        // Cells outside the active area keep their stored value.
        assign next_row[c] = col_mask[c] ? live_next : middle[c];
    end
endmodule

[rtl/core/life_cellular_automaton_grid.sv]
// Top level of the cell grid block: sequencer, configuration and result register.
// Depends on gol_pkg, gol_in_if, gol_out_if, gol_row_mem and gol_row_eval.
`timescale 1ns / 1ps

// Game of Life grid (B3/S23) with rows held in a single-port-read memory.
// After reset the block sweeps the memory to clear it, and no word is
// accepted during the sweep; configuration writes are taken at any time.
// One word is in work at a time. A cell write or read passes through the
// cell state and the done state before it reaches the result register; a
// generation step on an area of nonzero height passes through a load state,
// one row state per active row and the done state, because the memory returns one row per
// cycle and the row evaluator turns out one new row per cycle from three row
// buffers. The next word can be accepted in the cycle after the result is
// registered. A finished result waits in the output register, and the next
// word is accepted while it waits.
module life_cellular_automaton_grid #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  logic                   clk,
    input  logic                   rst_n,
    gol_in_if.sink                 in_ch,
    gol_out_if.source              out_ch,
    input  logic                   cfg_write,
    input  gol_pkg::cfg_index_t    cfg_index,
    input  logic [gol_pkg::CFG_W-1:0] cfg_data
);
    import gol_pkg::*;

    localparam int AW = $clog2(MAX_HEIGHT);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int SW = HW + 1;
    localparam logic [AW-1:0] LAST_ROW = AW'(MAX_HEIGHT - 1);

    state_t state_reg, state_next;

    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    logic [CFG_W-1:0] eff_w;
    logic [HW-1:0]    eff_h;
    logic [MAX_WIDTH-1:0] col_mask;

    logic [AW-1:0]       wi_reg;
    logic [SW-1:0]       wi_p1;
    logic [SW-1:0]       wi_p2;
    logic [SW-1:0]       eh_x;
    logic                step_last;

    logic [ACTION_W-1:0] act_reg;
    logic [AW-1:0]       row_reg;
    logic [MAX_WIDTH-1:0] col_bit_reg;
    logic                val_reg;
    logic                ok_reg;

    logic [MAX_WIDTH-1:0] prev_reg;
    logic [MAX_WIDTH-1:0] cur_reg;
    logic [MAX_WIDTH-1:0] nxt_row;
    logic [MAX_WIDTH-1:0] new_row;

    logic                res_cell_reg;
    logic                res_tick_reg;
    logic                out_valid_reg;
    logic                out_cell_reg;
    logic                out_tick_reg;

    logic                in_accept;
    logic                in_ok;
    logic                out_free;
    logic                cell_bit;

    logic                 mem_wr_en;
    logic [AW-1:0]        mem_wr_addr;
    logic [MAX_WIDTH-1:0] mem_wr_data;
    logic                 mem_rd_en;
    logic [AW-1:0]        mem_rd_addr;
    logic [MAX_WIDTH-1:0] mem_rd_data;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_RESET;
            height_reg <= DIM_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_WIDTH:  width_reg  <= cfg_data;
                CFG_HEIGHT: height_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    assign eff_w = (int'(width_reg) > MAX_WIDTH) ? CFG_W'(MAX_WIDTH) : width_reg;
    assign eff_h = (int'(height_reg) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(height_reg);

    always_comb
    begin
        for (int c = 0; c < MAX_WIDTH; c++)
        begin
            col_mask[c] = (c < int'(eff_w));
        end
    end

    assign in_accept = in_ch.valid && in_ch.ready;
    assign in_ok     = (int'(in_ch.row) < int'(eff_h)) && (int'(in_ch.col) < int'(eff_w));
    assign out_free  = !out_valid_reg || out_ch.ready;

    assign wi_p1     = SW'(wi_reg) + SW'(1);
    assign wi_p2     = SW'(wi_reg) + SW'(2);
    assign eh_x      = SW'(eff_h);
    assign step_last = (wi_p1 == eh_x);
    // The row below the last active row reads as dead.
    assign nxt_row   = (wi_p1 < eh_x) ? mem_rd_data : '0;
    assign cell_bit  = |(mem_rd_data & col_bit_reg);

    gol_row_mem #(
        .WIDTH (MAX_WIDTH),
        .DEPTH (MAX_HEIGHT),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    gol_row_eval #(
        .WIDTH (MAX_WIDTH)
    ) u_eval (
        .above    (prev_reg),
        .middle   (cur_reg),
        .below    (nxt_row),
        .col_mask (col_mask),
        .next_row (new_row)
    );

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (wi_reg == LAST_ROW)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    case (in_ch.action) inside
                        ACT_WRITE, ACT_READ: state_next = ST_CELL;
                        ACT_STEP:   state_next = (eff_h == '0) ? ST_DONE : ST_STEP_LOAD;
                        default:    state_next = ST_DONE;
                    endcase
                end
            end
            ST_CELL:      state_next = ST_DONE;
            ST_STEP_LOAD: state_next = ST_STEP_ROW;
            ST_STEP_ROW:
            begin
                if (step_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Memory port control.
    always_comb
    begin
        mem_wr_en   = 1'b0;
        mem_wr_addr = wi_reg;
        mem_wr_data = new_row;
        mem_rd_en   = 1'b0;
        mem_rd_addr = AW'(wi_p2);
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_data = '0;
            end
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (in_ch.action == ACT_STEP)
                    begin
                        mem_rd_en   = (eff_h != '0);
                        mem_rd_addr = '0;
                    end
                    else
                    begin
                        mem_rd_en   = in_ok;
                        mem_rd_addr = AW'(in_ch.row);
                    end
                end
            end
            ST_CELL:
            begin
                mem_wr_en   = ok_reg && (act_reg == ACT_WRITE);
                mem_wr_addr = row_reg;
                mem_wr_data = val_reg ? (mem_rd_data | col_bit_reg)
                                      : (mem_rd_data & ~col_bit_reg);
            end
            ST_STEP_LOAD:
            begin
                mem_rd_en   = (SW'(1) < eh_x);
                mem_rd_addr = AW'(1);
            end
            ST_STEP_ROW:
            begin
                mem_wr_en = 1'b1;
                mem_rd_en = (wi_p2 < eh_x);
            end
            ST_DONE: ;
            default: ;
        endcase
    end

    assign in_ch.ready = (state_reg == ST_IDLE);

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            wi_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                wi_reg <= (wi_reg == LAST_ROW) ? '0 : AW'(wi_p1);
            end
            else if (state_reg == ST_STEP_LOAD)
            begin
                wi_reg <= '0;
            end
            else if (state_reg == ST_STEP_ROW)
            begin
                wi_reg <= AW'(wi_p1);
            end

            if ((state_reg == ST_DONE) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Item, row buffer and result registers.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            act_reg      <= in_ch.action;
            row_reg      <= AW'(in_ch.row);
            col_bit_reg  <= MAX_WIDTH'(1) << in_ch.col;
            val_reg      <= in_ch.cell_in;
            ok_reg       <= in_ok;
            res_cell_reg <= 1'b0;
            res_tick_reg <= (in_ch.action == ACT_STEP);
        end
        if (state_reg == ST_CELL)
        begin
            res_cell_reg <= ok_reg && (act_reg == ACT_READ) && cell_bit;
        end
        if (state_reg == ST_STEP_LOAD)
        begin
            prev_reg <= '0;
            cur_reg  <= mem_rd_data;
        end
        else if (state_reg == ST_STEP_ROW)
        begin
            prev_reg <= cur_reg;
            cur_reg  <= nxt_row;
        end
        if ((state_reg == ST_DONE) && out_free)
        begin
            out_cell_reg <= res_cell_reg;
            out_tick_reg <= res_tick_reg;
        end
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.cell_out  = out_cell_reg;
    assign out_ch.tick_done = out_tick_reg;
endmodule

[rtl/core/gol_checker.sv]
// Port-level checks of the cell grid block, bound to the top level.
// Depends on life_cellular_automaton_grid_defines.svh.
`timescale 1ns / 1ps
`include "life_cellular_automaton_grid_defines.svh"

module gol_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic cell_out,
    input logic tick_done
);
    // A stalled result word holds its value until taken.
    `GOL_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(cell_out) && $stable(tick_done), "result word changed while stalled")

    // A result is either a read value or a step completion, never both.
    `GOL_ASSERT_IMP(a_out_excl, clk, rst_n, out_valid, !(cell_out && tick_done), "read value and step completion both set")

    // Only one word is in work at a time.
    `GOL_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready, "ready stayed high after a word was accepted")
endmodule

bind life_cellular_automaton_grid gol_checker u_gol_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cell_out  (out_ch.cell_out),
    .tick_done (out_ch.tick_done)
);

[dv/life_cellular_automaton_grid_tb.sv]
// Self-checking testbench for the Game of Life grid block (B3/S23, no wrap).
// Depends on gol_pkg, gol_in_if, gol_out_if and the life_cellular_automaton_grid RTL.
// A built-in grid predictor checks every result word against the block.
`timescale 1ns / 1ps

module life_cellular_automaton_grid_tb;
    import gol_pkg::*;

    localparam int GRID_MAX_COLS = 64;
    localparam int GRID_MAX_ROWS = 64;
    localparam int LIVE_MIN      = 2;
    localparam int LIVE_BIRTH    = 3;
    localparam int PHASE_WORDS   = 60;
    localparam int RANDOM_PHASES = 20;
    localparam int LONG_HOLD     = 400;
    localparam int DRAIN_CYCLES  = 100;

    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [POS_W-1:0]    row;
        logic [POS_W-1:0]    col;
        logic                cell_in;
    } grid_command_t;

    typedef struct packed {
        logic cell_out;
        logic tick_done;
    } grid_reply_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_write;
    cfg_index_t       cfg_index;
    logic [CFG_W-1:0] cfg_data;

    gol_in_if  in_ch ();
    gol_out_if out_ch ();

    life_cellular_automaton_grid #(
        .MAX_WIDTH  (GRID_MAX_COLS),
        .MAX_HEIGHT (GRID_MAX_ROWS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predicted state of the block.
    logic [GRID_MAX_COLS-1:0] grid_state [GRID_MAX_ROWS];
    logic [CFG_W-1:0]         grid_cols;
    logic [CFG_W-1:0]         grid_rows;

    grid_command_t command_queue [$];
    grid_reply_t   grid_replies [$];

    int failures     = 0;
    int replies_seen = 0;
    int burst_left   = 0;
    int gap_left     = 0;
    int hold_left    = 0;
    bit hold_done    = 1'b0;
    int seg_left     = 0;
    int seg_mode     = 0;

    function automatic int live_cols();
        return (grid_cols > GRID_MAX_COLS) ? GRID_MAX_COLS : int'(grid_cols);
    endfunction

    function automatic int live_rows();
        return (grid_rows > GRID_MAX_ROWS) ? GRID_MAX_ROWS : int'(grid_rows);
    endfunction

    // Cells outside the active area keep their value and read as dead neighbors.
    function automatic void advance_generation();
        logic [GRID_MAX_COLS-1:0] prior [GRID_MAX_ROWS];
        int w;
        int h;
        int n;
        int rr;
        int cc;
        prior = grid_state;
        w = live_cols();
        h = live_rows();
        for (int r = 0; r < h; r++)
        begin
            for (int c = 0; c < w; c++)
            begin
                n = 0;
                for (int dr = -1; dr <= 1; dr++)
                begin
                    for (int dc = -1; dc <= 1; dc++)
                    begin
                        rr = r + dr;
                        cc = c + dc;
                        if ((dr != 0 || dc != 0) && rr >= 0 && cc >= 0 && rr < h && cc < w)
                            n += int'(prior[rr][cc]);
                    end
                end
                if (prior[r][c])
                    grid_state[r][c] = (n == LIVE_MIN || n == LIVE_BIRTH);
                else
                    grid_state[r][c] = (n == LIVE_BIRTH);
            end
        end
    endfunction

    function automatic grid_reply_t run_grid_command(grid_command_t cmd);
        grid_reply_t reply;
        logic        hit;
        reply = '0;
        hit = (int'(cmd.row) < live_rows()) && (int'(cmd.col) < live_cols());
        if (cmd.action == ACT_WRITE)
        begin
            if (hit)
                grid_state[cmd.row][cmd.col] = cmd.cell_in;
        end
        else if (cmd.action == ACT_READ)
        begin
            if (hit)
                reply.cell_out = grid_state[cmd.row][cmd.col];
        end
        else if (cmd.action == ACT_STEP)
        begin
            advance_generation();
            reply.tick_done = 1'b1;
        end
        return reply;
    endfunction

    function automatic void push_command(logic [ACTION_W-1:0] act, int r, int c, logic val);
        grid_command_t cmd;
        cmd.action  = act;
        cmd.row     = r[POS_W-1:0];
        cmd.col     = c[POS_W-1:0];
        cmd.cell_in = val;
        command_queue.push_back(cmd);
    endfunction

    // A position inside the active area, or anywhere when the area is empty.
    function automatic int pick_pos(int span);
        if (span == 0)
            return $urandom_range(0, 63);
        return $urandom_range(0, span - 1);
    endfunction

    // Seed the area first, then mix reads, writes and steps with some noise.
    function automatic void queue_phase(int count);
        int w;
        int h;
        int roll;
        w = live_cols();
        h = live_rows();
        for (int i = 0; i < count; i++)
        begin
            roll = $urandom_range(0, 99);
            if (i < count / 3)
                push_command(ACT_WRITE, pick_pos(h), pick_pos(w), $urandom_range(0, 4) < 2);
            else if (roll < 30)
                push_command(ACT_WRITE, pick_pos(h), pick_pos(w), $urandom_range(0, 1));
            else if (roll < 65)
                push_command(ACT_READ, pick_pos(h), pick_pos(w), $urandom_range(0, 1));
            else if (roll < 80)
                push_command(ACT_STEP, $urandom_range(0, 63), $urandom_range(0, 63),
                             $urandom_range(0, 1));
            else if (roll < 92)
                push_command($urandom_range(0, 1) ? ACT_READ : ACT_WRITE,
                             $urandom_range(0, 63), $urandom_range(0, 63),
                             $urandom_range(0, 1));
            else
                push_command(ACT_UNUSED, $urandom_range(0, 63), $urandom_range(0, 63),
                             $urandom_range(0, 1));
        end
    endfunction

    task automatic wait_for_idle();
        do
            @(negedge clk);
        while (command_queue.size() != 0 || in_ch.valid || grid_replies.size() != 0);
    endtask

    task automatic write_dims(int cols, int rows);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= CFG_WIDTH;
        cfg_data  <= cols[CFG_W-1:0];
        @(posedge clk);
        cfg_index <= CFG_HEIGHT;
        cfg_data  <= rows[CFG_W-1:0];
        @(posedge clk);
        cfg_write <= 1'b0;
        grid_cols = cols[CFG_W-1:0];
        grid_rows = rows[CFG_W-1:0];
    endtask

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // Sender: bursts of random length separated by random gaps.
    always @(posedge clk)
    begin : feed_commands
        grid_command_t cmd;
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                cmd.action  = in_ch.action;
                cmd.row     = in_ch.row;
                cmd.col     = in_ch.col;
                cmd.cell_in = in_ch.cell_in;
                grid_replies.push_back(run_grid_command(cmd));
            end
            if (!in_ch.valid || in_ch.ready)
            begin
                if (gap_left != 0)
                begin
                    gap_left    <= gap_left - 1;
                    in_ch.valid <= 1'b0;
                end
                else if (command_queue.size() != 0)
                begin
                    cmd = command_queue.pop_front();
                    in_ch.valid   <= 1'b1;
                    in_ch.action  <= cmd.action;
                    in_ch.row     <= cmd.row;
                    in_ch.col     <= cmd.col;
                    in_ch.cell_in <= cmd.cell_in;
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 24);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                    else
                    begin
                        burst_left <= burst_left - 1;
                    end
                end
                else
                begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: segments of steady, random or sparse ready, plus one long hold-off
    // while words are still queued so the block backs up into its input.
    always @(posedge clk)
    begin : pace_replies
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left    <= hold_left - 1;
            out_ch.ready <= 1'b0;
        end
        else if (!hold_done && replies_seen >= 300 && command_queue.size() > 20)
        begin
            hold_done    <= 1'b1;
            hold_left    <= LONG_HOLD;
            out_ch.ready <= 1'b0;
        end
        else
        begin
            if (seg_left == 0)
            begin
                seg_left <= $urandom_range(8, 64);
                seg_mode <= $urandom_range(0, 2);
            end
            else
            begin
                seg_left <= seg_left - 1;
            end
            case (seg_mode)
                0:       out_ch.ready <= 1'b1;
                1:       out_ch.ready <= $urandom_range(0, 1);
                default: out_ch.ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin : check_replies
        grid_reply_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            replies_seen <= replies_seen + 1;
            if (grid_replies.size() == 0)
            begin
                $error("result word arrived with nothing awaited");
                failures++;
            end
            else
            begin
                want = grid_replies.pop_front();
                if (out_ch.cell_out !== want.cell_out)
                begin
                    $error("cell_out: expected %0b, actual %0b", want.cell_out, out_ch.cell_out);
                    failures++;
                end
                if (out_ch.tick_done !== want.tick_done)
                begin
                    $error("tick_done: expected %0b, actual %0b", want.tick_done,
                           out_ch.tick_done);
                    failures++;
                end
            end
        end
    end

    initial
    begin : run_phases
        int pick;
        int cols;
        int rows;
        rst_n         = 1'b0;
        cfg_write     = 1'b0;
        cfg_index     = CFG_WIDTH;
        cfg_data      = '0;
        in_ch.valid   = 1'b0;
        in_ch.action  = ACT_WRITE;
        in_ch.row     = '0;
        in_ch.col     = '0;
        in_ch.cell_in = 1'b0;
        out_ch.ready  = 1'b0;
        for (int r = 0; r < GRID_MAX_ROWS; r++)
            grid_state[r] = '0;
        grid_cols = DIM_RESET;
        grid_rows = DIM_RESET;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Full grid after reset: an L-shaped corner grows into a block and a lone
        // cell in the far corner dies. The unused action code must change nothing.
        push_command(ACT_WRITE, 63, 63, 1'b1);
        push_command(ACT_WRITE, 0, 0, 1'b1);
        push_command(ACT_WRITE, 0, 1, 1'b1);
        push_command(ACT_WRITE, 1, 0, 1'b1);
        push_command(ACT_READ, 0, 0, 1'b0);
        push_command(ACT_READ, 63, 63, 1'b0);
        push_command(ACT_UNUSED, 63, 63, 1'b1);
        push_command(ACT_READ, 63, 63, 1'b0);
        push_command(ACT_STEP, 0, 0, 1'b0);
        push_command(ACT_READ, 1, 1, 1'b0);
        push_command(ACT_READ, 63, 63, 1'b0);
        push_command(ACT_READ, 0, 0, 1'b0);
        wait_for_idle();

        // Tiny area: writes and reads just past the edge are dropped.
        write_dims(3, 3);
        push_command(ACT_WRITE, 2, 2, 1'b1);
        push_command(ACT_WRITE, 3, 0, 1'b1);
        push_command(ACT_READ, 0, 3, 1'b0);
        push_command(ACT_STEP, 0, 0, 1'b0);
        push_command(ACT_READ, 1, 1, 1'b0);
        wait_for_idle();

        // Zero width: nothing is in range, yet a step still reports done.
        write_dims(0, 5);
        push_command(ACT_WRITE, 0, 0, 1'b1);
        push_command(ACT_READ, 0, 0, 1'b0);
        push_command(ACT_STEP, 0, 0, 1'b0);
        wait_for_idle();

        // Oversized dimensions clamp to the full grid.
        write_dims(127, 127);
        push_command(ACT_READ, 63, 63, 1'b0);
        push_command(ACT_STEP, 0, 0, 1'b0);
        push_command(ACT_READ, 3, 0, 1'b0);
        wait_for_idle();

        // Zero height.
        write_dims(64, 0);
        push_command(ACT_STEP, 0, 0, 1'b0);
        push_command(ACT_READ, 0, 0, 1'b0);
        wait_for_idle();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 10)
            begin
                cols = $urandom_range(1, 12);
                rows = $urandom_range(1, 12);
            end
            else if (pick < 13)
            begin
                cols = GRID_MAX_COLS;
                rows = GRID_MAX_ROWS;
            end
            else if (pick < 15)
            begin
                cols = $urandom_range(0, 1) ? 0 : $urandom_range(0, 10);
                rows = (cols == 0) ? $urandom_range(0, 10) : 0;
            end
            else if (pick < 17)
            begin
                cols = $urandom_range(65, 127);
                rows = $urandom_range(65, 127);
            end
            else
            begin
                cols = $urandom_range(1, 64);
                rows = $urandom_range(1, 64);
            end
            write_dims(cols, rows);
            queue_phase(PHASE_WORDS);
            wait_for_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/gol_pkg.sv
rtl/core/gol_in_if.sv
rtl/core/gol_out_if.sv
rtl/core/gol_row_mem.sv
rtl/core/gol_row_eval.sv
rtl/core/life_cellular_automaton_grid.sv
rtl/core/gol_checker.sv
dv/life_cellular_automaton_grid_tb.sv
